[design/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dpath and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

    localparam int W_OP   = 2;
    localparam int W_SIZE = 30;
    localparam int W_ADDR = 29;
    localparam int W_ST   = 3;
    localparam int W_HEAP = 30;

    localparam int DEF_MAX_BLOCKS      = 64;
    localparam int DEF_HEADER_BYTES    = 48;
    localparam int DEF_ALIGN_BYTES     = 8;
    localparam int DEF_HEAP_LIMIT      = 536870912;
    localparam int HEAP_MIN_BYTES      = 4096;
    localparam int HEAP_RESET_BYTES    = 16777216;

    typedef enum logic [W_OP-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [W_ST-1:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_ZERO    = 3'd2,
        ST_BADADDR = 3'd3,
        ST_FREED   = 3'd4
    } t_status;

    // one table entry: header offset, payload size, free mark
    typedef struct packed {
        logic [W_HEAP-1:0] hdr;
        logic [W_HEAP-1:0] size;
        logic              free;
    } t_entry;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ALIGN, S_DECODE, S_SCAN_RD, S_SCAN_CK, S_RSZ_CK,
        S_RESCAN, S_SPLIT_CHK, S_SHU_RD, S_SHU_WR, S_WR_USED, S_FR_NXT_RD,
        S_FR_NXT_CK, S_RM_RD, S_RM_WR, S_FR_PRV_RD, S_FR_PRV_CK, S_FR_WR,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        M_ALLOC, M_FREE, M_RESIZE, M_GROW, M_GROW_FREE
    } t_mode;

    typedef enum logic [4:0] {
        DP_NONE, DP_INIT, DP_CFG, DP_LATCH, DP_ALIGN, DP_SCAN_START, DP_SCAN_RD,
        DP_SCAN_NEXT, DP_SCAN_TAKE, DP_SPLIT_START, DP_SHU_RD, DP_SHU_WR,
        DP_SPLIT_INS, DP_WR_USED, DP_FR_NXT_RD, DP_FR_NXT_MERGE, DP_RM_RD,
        DP_RM_WR, DP_RM_END, DP_FR_PRV_RD, DP_FR_PRV_MERGE, DP_WR_FREE,
        DP_RESULT
    } t_dp_op;

    typedef enum logic [1:0] {
        RS_ZERO, RS_ADDR, RS_NEW
    } t_res_sel;

    typedef struct packed {
        t_dp_op   op;
        t_status  st;
        t_res_sel sel;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    size_zero;
        logic    addr_zero;
        logic    align_done;
        logic    scan_end;
        logic    fit_hit;
        logic    addr_hit;
        logic    rd_free;
        logic    shrink_ok;
        logic    split_ok;
        logic    shu_more;
        logic    has_next;
        logic    has_prev;
        logic    rm_more;
        logic    out_free;
    } t_dp_stat;

endpackage

[design/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with split and free-neighbour merge.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_opcode, i_size_bytes, i_address
//  out     | o_out_valid| i_out_ready | o_result_address, o_status
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_heap_bytes
//
// One request at a time. A request is accepted, aligned (reciprocal multiply, then
// remainder), decoded and answered, with table walks in between through the block
// table: scan, shift-up on split, shift-down on merge. Alloc walks at most twice,
// free three times, a growing resize up to six times (old block, fit, shift-up,
// rescan, two shift-downs). Reset is synchronous; after it the INIT state writes
// entry 0 as the whole heap. The result sits in an output register, so a stalled
// result consumer only blocks once the next request is finished.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS       = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES     = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES      = ffha_pkg::DEF_ALIGN_BYTES,
    parameter int HEAP_LIMIT_BYTES = ffha_pkg::DEF_HEAP_LIMIT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ffha_pkg::W_OP-1:0]   i_opcode,
    input  logic [ffha_pkg::W_SIZE-1:0] i_size_bytes,
    input  logic [ffha_pkg::W_ADDR-1:0] i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ffha_pkg::W_ADDR-1:0] o_result_address,
    output logic [ffha_pkg::W_ST-1:0]   o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ffha_pkg::W_HEAP-1:0] i_cfg_heap_bytes
);
    import ffha_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // sequencer: decides every step, owns request mode and handshakes
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // block table, arithmetic and result register
    ffha_dpath #(
        .MAX_BLOCKS       (MAX_BLOCKS),
        .HEADER_BYTES     (HEADER_BYTES),
        .ALIGN_BYTES      (ALIGN_BYTES),
        .HEAP_LIMIT_BYTES (HEAP_LIMIT_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_heap_bytes (i_cfg_heap_bytes),
        .i_opcode         (i_opcode),
        .i_size_bytes     (i_size_bytes),
        .i_address        (i_address),
        .i_out_ready      (i_out_ready),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

endmodule

[design/ffha_ctrl.sv]
// Sequencer of the heap allocator: walks scan, split, merge and shift steps.
// Depends on ffha_pkg; drives ffha_dpath by command, reads its status.
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cfg_valid,
    input  ffha_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_cfg_ready,
    output ffha_pkg::t_cmd    o_cmd
);
    import ffha_pkg::*;

    t_state   r_state, n_state;
    t_mode    r_mode, n_mode;
    logic     r_rm_second, n_rm_second;
    t_status  r_res_st, n_res_st;
    t_res_sel r_res_sel, n_res_sel;
    logic     fit_mode;

    assign fit_mode = (r_mode == M_ALLOC) || (r_mode == M_GROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_mode      <= M_ALLOC;
            r_rm_second <= 1'b0;
            r_res_st    <= ST_OK;
            r_res_sel   <= RS_ZERO;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_rm_second <= n_rm_second;
            r_res_st    <= n_res_st;
            r_res_sel   <= n_res_sel;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_rm_second = r_rm_second;
        n_res_st    = r_res_st;
        n_res_sel   = r_res_sel;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        o_cmd.op    = DP_NONE;
        o_cmd.st    = r_res_st;
        o_cmd.sel   = r_res_sel;
        case (r_state)
            S_INIT: begin
                o_cmd.op = DP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.op = DP_CFG;
                    n_state  = S_INIT;
                end else if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = S_ALIGN;
                end
            end
            S_ALIGN: begin
                o_cmd.op = DP_ALIGN;
                if (i_stat.align_done) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.op  = DP_SCAN_START;
                n_state   = S_SCAN_RD;
                n_res_st  = ST_OK;
                n_res_sel = RS_ZERO;
                case (i_stat.op)
                    OP_ALLOC: begin
                        n_mode = M_ALLOC;
                        if (i_stat.size_zero) begin
                            n_res_st = ST_ZERO;
                            n_state  = S_RESULT;
                        end
                    end
                    OP_FREE: begin
                        n_mode = M_FREE;
                        if (i_stat.addr_zero) n_state = S_RESULT;
                    end
                    OP_RESIZE: begin
                        if (i_stat.addr_zero) begin
                            n_mode = M_ALLOC;
                            if (i_stat.size_zero) begin
                                n_res_st = ST_ZERO;
                                n_state  = S_RESULT;
                            end
                        end else if (i_stat.size_zero) begin
                            n_mode = M_FREE;
                        end else begin
                            n_mode = M_RESIZE;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    n_res_sel = RS_ZERO;
                    n_res_st  = fit_mode ? ST_NOSPACE : ST_BADADDR;
                    n_state   = S_RESULT;
                end else begin
                    o_cmd.op = DP_SCAN_RD;
                    n_state  = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (fit_mode ? i_stat.fit_hit : i_stat.addr_hit) begin
                    o_cmd.op = DP_SCAN_TAKE;
                    if (fit_mode) begin
                        n_state = S_SPLIT_CHK;
                    end else if (i_stat.rd_free) begin
                        n_res_st  = ST_FREED;
                        n_res_sel = RS_ZERO;
                        n_state   = S_RESULT;
                    end else if (r_mode == M_RESIZE) begin
                        n_state = S_RSZ_CK;
                    end else begin
                        n_state = S_FR_NXT_RD;
                    end
                end else begin
                    o_cmd.op = DP_SCAN_NEXT;
                    n_state  = S_SCAN_RD;
                end
            end
            S_RSZ_CK: begin
                if (i_stat.shrink_ok) begin
                    n_state = S_SPLIT_CHK;
                end else begin
                    o_cmd.op = DP_SCAN_START;
                    n_mode   = M_GROW;
                    n_state  = S_SCAN_RD;
                end
            end
            S_RESCAN: begin
                o_cmd.op = DP_SCAN_START;
                n_mode   = M_GROW_FREE;
                n_state  = S_SCAN_RD;
            end
            S_SPLIT_CHK: begin
                if (i_stat.split_ok) begin
                    o_cmd.op = DP_SPLIT_START;
                    n_state  = S_SHU_RD;
                end else begin
                    n_state = S_WR_USED;
                end
            end
            S_SHU_RD: begin
                if (i_stat.shu_more) begin
                    o_cmd.op = DP_SHU_RD;
                    n_state  = S_SHU_WR;
                end else begin
                    o_cmd.op = DP_SPLIT_INS;
                    n_state  = S_WR_USED;
                end
            end
            S_SHU_WR: begin
                o_cmd.op = DP_SHU_WR;
                n_state  = S_SHU_RD;
            end
            S_WR_USED: begin
                o_cmd.op = DP_WR_USED;
                n_res_st = ST_OK;
                case (r_mode)
                    M_ALLOC: begin
                        n_res_sel = RS_NEW;
                        n_state   = S_RESULT;
                    end
                    M_RESIZE: begin
                        n_res_sel = RS_ADDR;
                        n_state   = S_RESULT;
                    end
                    default: n_state = S_RESCAN;
                endcase
            end
            S_FR_NXT_RD: begin
                if (i_stat.has_next) begin
                    o_cmd.op = DP_FR_NXT_RD;
                    n_state  = S_FR_NXT_CK;
                end else begin
                    n_state = S_FR_PRV_RD;
                end
            end
            S_FR_NXT_CK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op    = DP_FR_NXT_MERGE;
                    n_rm_second = 1'b0;
                    n_state     = S_RM_RD;
                end else begin
                    n_state = S_FR_PRV_RD;
                end
            end
            S_RM_RD: begin
                if (i_stat.rm_more) begin
                    o_cmd.op = DP_RM_RD;
                    n_state  = S_RM_WR;
                end else begin
                    o_cmd.op = DP_RM_END;
                    if (r_rm_second) begin
                        n_res_st  = ST_OK;
                        n_res_sel = (r_mode == M_GROW_FREE) ? RS_NEW : RS_ZERO;
                        n_state   = S_RESULT;
                    end else begin
                        n_state = S_FR_PRV_RD;
                    end
                end
            end
            S_RM_WR: begin
                o_cmd.op = DP_RM_WR;
                n_state  = S_RM_RD;
            end
            S_FR_PRV_RD: begin
                if (i_stat.has_prev) begin
                    o_cmd.op = DP_FR_PRV_RD;
                    n_state  = S_FR_PRV_CK;
                end else begin
                    n_state = S_FR_WR;
                end
            end
            S_FR_PRV_CK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op    = DP_FR_PRV_MERGE;
                    n_rm_second = 1'b1;
                    n_state     = S_RM_RD;
                end else begin
                    n_state = S_FR_WR;
                end
            end
            S_FR_WR: begin
                o_cmd.op  = DP_WR_FREE;
                n_res_st  = ST_OK;
                n_res_sel = (r_mode == M_GROW_FREE) ? RS_NEW : RS_ZERO;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

[design/ffha_dpath.sv]
// Datapath of the heap allocator: block table memory, work registers, result register.
// Depends on ffha_pkg; steered by ffha_ctrl commands.
module ffha_dpath #(
    parameter int MAX_BLOCKS       = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES     = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ALIGN_BYTES      = ffha_pkg::DEF_ALIGN_BYTES,
    parameter int HEAP_LIMIT_BYTES = ffha_pkg::DEF_HEAP_LIMIT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffha_pkg::t_cmd              i_cmd,
    input  logic [ffha_pkg::W_HEAP-1:0] i_cfg_heap_bytes,
    input  logic [ffha_pkg::W_OP-1:0]   i_opcode,
    input  logic [ffha_pkg::W_SIZE-1:0] i_size_bytes,
    input  logic [ffha_pkg::W_ADDR-1:0] i_address,
    input  logic                        i_out_ready,
    output ffha_pkg::t_dp_stat          o_stat,
    output logic                        o_out_valid,
    output logic [ffha_pkg::W_ADDR-1:0] o_result_address,
    output logic [ffha_pkg::W_ST-1:0]   o_status
);
    import ffha_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(ALIGN_BYTES) + 1;
    localparam int RW = W_SIZE + 1;
    localparam logic [31:0] HDR  = 32'(HEADER_BYTES);
    localparam logic [31:0] ALN  = 32'(ALIGN_BYTES);
    localparam logic [W_HEAP-1:0] HEAP_LIM = W_HEAP'(HEAP_LIMIT_BYTES);
    localparam logic [W_HEAP-1:0] HEAP_MIN = W_HEAP'(HEAP_MIN_BYTES);
    // floor(2^32 / ALIGN_BYTES): quotient estimate is exact or one short
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(ALIGN_BYTES));

    t_entry mem [MAX_BLOCKS];

    logic [W_HEAP-1:0] r_heap;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_k;
    logic [IW-1:0]     r_idx;
    t_entry            r_ent;
    t_entry            r_rd;
    t_opcode           r_op;
    logic [W_SIZE-1:0] r_size;
    logic [W_ADDR-1:0] r_addr;
    logic [AW-1:0]     r_rem;
    logic              r_phase;
    logic [W_SIZE-1:0] r_quo;
    logic [RW-1:0]     r_req;
    logic [W_HEAP:0]   r_new;
    logic              r_out_valid;
    logic [W_ADDR-1:0] r_res_addr;
    t_status           r_res_st;

    logic              we;
    logic [IW-1:0]     waddr;
    t_entry            wdata;
    logic              re;
    logic [IW-1:0]     raddr;
    logic [62:0]       quo_prod;
    logic [31:0]       rem_full;
    logic [AW-1:0]     rem_step;
    logic [31:0]       split_need;
    logic [CW-1:0]     idx_c;
    t_entry            nb;

    assign idx_c      = CW'(r_idx);
    assign split_need = 32'(r_req) + HDR + ALN;
    assign quo_prod   = 63'(r_size) * 63'(RECIP);
    assign rem_full   = 32'(r_size) - 32'(r_quo) * ALN;
    assign rem_step   = (rem_full >= ALN) ? AW'(rem_full - ALN) : AW'(rem_full);
    assign nb.hdr     = W_HEAP'(32'(r_ent.hdr) + HDR + 32'(r_req));
    assign nb.size    = W_HEAP'(32'(r_ent.size) - 32'(r_req) - HDR);
    assign nb.free    = 1'b1;

    // status back to the sequencer
    always_comb begin
        o_stat.op         = r_op;
        o_stat.size_zero  = (r_size == '0);
        o_stat.addr_zero  = (r_addr == '0);
        o_stat.align_done = !r_phase;
        o_stat.scan_end   = (r_i >= r_count);
        o_stat.fit_hit    = r_rd.free && (32'(r_rd.size) >= 32'(r_req));
        o_stat.addr_hit   = (32'(r_rd.hdr) + HDR) == 32'(r_addr);
        o_stat.rd_free    = r_rd.free;
        o_stat.shrink_ok  = 32'(r_req) <= 32'(r_ent.size);
        o_stat.split_ok   = (32'(r_ent.size) >= split_need) &&
                            (32'(r_count) < 32'(MAX_BLOCKS));
        o_stat.shu_more   = r_k > (idx_c + CW'(1));
        o_stat.has_next   = (idx_c + CW'(1)) < r_count;
        o_stat.has_prev   = (r_idx != '0);
        o_stat.rm_more    = (r_k + CW'(1)) < r_count;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port steering
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_rd;
        re    = 1'b0;
        raddr = r_i[IW-1:0];
        case (i_cmd.op)
            DP_INIT: begin
                we         = 1'b1;
                waddr      = '0;
                wdata.hdr  = '0;
                wdata.size = W_HEAP'(32'(r_heap) - HDR);
                wdata.free = 1'b1;
            end
            DP_SCAN_RD:   re = 1'b1;
            DP_SHU_RD: begin
                re    = 1'b1;
                raddr = IW'(r_k - CW'(1));
            end
            DP_SHU_WR: begin
                we    = 1'b1;
                waddr = r_k[IW-1:0];
            end
            DP_SPLIT_INS: begin
                we    = 1'b1;
                waddr = IW'(idx_c + CW'(1));
                wdata = nb;
            end
            DP_WR_USED: begin
                we    = 1'b1;
                wdata = '{hdr: r_ent.hdr, size: r_ent.size, free: 1'b0};
            end
            DP_FR_NXT_RD: begin
                re    = 1'b1;
                raddr = IW'(idx_c + CW'(1));
            end
            DP_RM_RD: begin
                re    = 1'b1;
                raddr = IW'(r_k + CW'(1));
            end
            DP_RM_WR: begin
                we    = 1'b1;
                waddr = r_k[IW-1:0];
            end
            DP_FR_PRV_RD: begin
                re    = 1'b1;
                raddr = r_idx - IW'(1);
            end
            DP_FR_PRV_MERGE: begin
                we         = 1'b1;
                waddr      = r_idx - IW'(1);
                wdata.hdr  = r_rd.hdr;
                wdata.size = W_HEAP'(32'(r_rd.size) + HDR + 32'(r_ent.size));
                wdata.free = 1'b1;
            end
            DP_WR_FREE: begin
                we    = 1'b1;
                wdata = '{hdr: r_ent.hdr, size: r_ent.size, free: 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap      <= W_HEAP'(HEAP_RESET_BYTES);
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_RESULT)           r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                DP_CFG: begin
                    if (i_cfg_heap_bytes < HEAP_MIN)      r_heap <= HEAP_MIN;
                    else if (i_cfg_heap_bytes > HEAP_LIM) r_heap <= HEAP_LIM;
                    else                                  r_heap <= i_cfg_heap_bytes;
                end
                DP_INIT:      r_count <= CW'(1);
                DP_SPLIT_INS: r_count <= r_count + CW'(1);
                DP_RM_END:    r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

    // work registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_op    <= t_opcode'(i_opcode);
                r_size  <= i_size_bytes;
                r_addr  <= i_address;
                r_rem   <= '0;
                r_phase <= 1'b1;
            end
            // first phase: quotient estimate; second phase: remainder with one fix-up
            DP_ALIGN: begin
                if (r_phase) r_quo <= quo_prod[32 +: W_SIZE];
                else         r_rem <= rem_step;
                r_phase <= 1'b0;
            end
            DP_SCAN_START: begin
                r_i   <= '0;
                r_req <= (r_rem == '0) ? RW'(r_size)
                                       : RW'(32'(r_size) + ALN - 32'(r_rem));
            end
            DP_SCAN_NEXT: r_i <= r_i + CW'(1);
            DP_SCAN_TAKE: begin
                r_idx <= r_i[IW-1:0];
                r_ent <= r_rd;
            end
            DP_SPLIT_START: r_k <= r_count;
            DP_SHU_WR:      r_k <= r_k - CW'(1);
            DP_SPLIT_INS:   r_ent.size <= W_HEAP'(r_req);
            DP_WR_USED:     r_new <= (W_HEAP + 1)'(32'(r_ent.hdr) + HDR);
            DP_FR_NXT_MERGE: begin
                r_ent.size <= W_HEAP'(32'(r_ent.size) + HDR + 32'(r_rd.size));
                r_k        <= idx_c + CW'(1);
            end
            DP_RM_WR:        r_k <= r_k + CW'(1);
            DP_FR_PRV_MERGE: r_k <= idx_c;
            DP_RESULT: begin
                r_res_st <= i_cmd.st;
                case (i_cmd.sel)
                    RS_ADDR: r_res_addr <= r_addr;
                    RS_NEW:  r_res_addr <= r_new[W_ADDR-1:0];
                    default: r_res_addr <= '0;
                endcase
            end
            default: ;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_res_addr;
    assign o_status         = r_res_st;

endmodule

[test/ffha_checker.sv]
`timescale 1ns / 1ps
// Request/result checker for the first-fit heap allocator: keeps its own block table.
// Depends on ffha_pkg; instantiated by first_fit_heap_allocator_tb.
module ffha_checker
    import ffha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [W_OP-1:0]   i_opcode,
    input  logic [W_SIZE-1:0] i_size_bytes,
    input  logic [W_ADDR-1:0] i_address,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [W_ADDR-1:0] i_result_address,
    input  logic [W_ST-1:0]   i_status,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [W_HEAP-1:0] i_cfg_heap_bytes,
    output int                o_fail_count,
    output int                o_pending
);
    localparam int MAXB = DEF_MAX_BLOCKS;
    localparam longint unsigned HDR = DEF_HEADER_BYTES;
    localparam longint unsigned ALN = DEF_ALIGN_BYTES;

    typedef struct packed {
        logic [W_ADDR-1:0] addr;
        logic [W_ST-1:0]   st;
    } t_grant;

    longint unsigned blk_hdr [MAXB];
    longint unsigned blk_size [MAXB];
    bit              blk_free [MAXB];
    int              blk_count;
    longint unsigned heap_size;
    t_grant          grant_q [$];
    int              fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = grant_q.size();

    function automatic void table_reset();
        blk_hdr[0]  = 0;
        blk_size[0] = heap_size - HDR;
        blk_free[0] = 1'b1;
        blk_count   = 1;
    endfunction

    function automatic void drop_block(int i);
        for (int k = i; k + 1 < blk_count; k++) begin
            blk_hdr[k] = blk_hdr[k+1]; blk_size[k] = blk_size[k+1]; blk_free[k] = blk_free[k+1];
        end
        blk_count--;
    endfunction

    // cut block i down to req bytes if it can be split; remainder becomes a new free block
    function automatic void carve(int i, longint unsigned req);
        longint unsigned nh, ns;
        if (blk_size[i] < req + HDR + ALN || blk_count >= MAXB) return;
        nh = blk_hdr[i] + HDR + req;
        ns = blk_size[i] - req - HDR;
        for (int k = blk_count; k > i + 1; k--) begin
            blk_hdr[k] = blk_hdr[k-1]; blk_size[k] = blk_size[k-1]; blk_free[k] = blk_free[k-1];
        end
        blk_hdr[i+1] = nh; blk_size[i+1] = ns; blk_free[i+1] = 1'b1;
        blk_count++;
        blk_size[i] = req;
    endfunction

    function automatic int lookup(longint unsigned addr);
        for (int i = 0; i < blk_count; i++)
            if (blk_hdr[i] + HDR == addr) return i;
        return -1;
    endfunction

    function automatic t_status take_first(longint unsigned size, output longint unsigned addr);
        longint unsigned req;
        addr = 0;
        if (size == 0) return ST_ZERO;
        req = ((size + ALN - 1) / ALN) * ALN;
        for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= req) begin
                carve(i, req);
                blk_free[i] = 1'b0;
                addr = blk_hdr[i] + HDR;
                return ST_OK;
            end
        end
        return ST_NOSPACE;
    endfunction

    function automatic t_status release_block(longint unsigned addr);
        int i;
        if (addr == 0) return ST_OK;
        i = lookup(addr);
        if (i < 0) return ST_BADADDR;
        if (blk_free[i]) return ST_FREED;
        blk_free[i] = 1'b1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] += HDR + blk_size[i+1];
            drop_block(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] += HDR + blk_size[i];
            drop_block(i);
        end
        return ST_OK;
    endfunction

    function automatic t_status rehome(longint unsigned addr, longint unsigned size,
                                       output longint unsigned res);
        int              i;
        longint unsigned req, naddr;
        t_status         st;
        res = 0;
        if (addr == 0) return take_first(size, res);
        if (size == 0) return release_block(addr);
        i = lookup(addr);
        if (i < 0) return ST_BADADDR;
        if (blk_free[i]) return ST_FREED;
        req = ((size + ALN - 1) / ALN) * ALN;
        if (req <= blk_size[i]) begin
            carve(i, req);   // shrink in place, no merge with next
            res = addr;
            return ST_OK;
        end
        st = take_first(req, naddr);
        if (st != ST_OK) return st;
        void'(release_block(addr));
        res = naddr;
        return ST_OK;
    endfunction

    initial begin
        heap_size = HEAP_RESET_BYTES;
        table_reset();
    end

    always @(posedge i_clk) begin
        longint unsigned res, v;
        t_status         st;
        t_grant          g, e;
        if (!i_rst_n) begin
            heap_size = HEAP_RESET_BYTES;
            table_reset();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                v = i_cfg_heap_bytes;
                if (v < HEAP_MIN_BYTES) v = HEAP_MIN_BYTES;
                if (v > DEF_HEAP_LIMIT) v = DEF_HEAP_LIMIT;
                heap_size = v;
                table_reset();
            end
            if (i_in_valid && i_in_ready) begin
                res = 0;
                case (t_opcode'(i_opcode))
                    OP_ALLOC:  st = take_first(i_size_bytes, res);
                    OP_FREE:   st = release_block(i_address);
                    OP_RESIZE: st = rehome(i_address, i_size_bytes, res);
                    default:   st = ST_OK;
                endcase
                g.addr = res[W_ADDR-1:0];
                g.st   = st;
                grant_q.push_back(g);
            end
            if (i_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    $error("result with no request outstanding: addr %0d status %0d",
                           i_result_address, i_status);
                    fails++;
                end else begin
                    e = grant_q.pop_front();
                    if (i_result_address !== e.addr) begin
                        $error("result_address: expected %0d, got %0d", e.addr, i_result_address);
                        fails++;
                    end
                    if (i_status !== e.st) begin
                        $error("status: expected %0d, got %0d", e.st, i_status);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

[test/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 1ps
// Testbench top for first_fit_heap_allocator: clock, reset, request and heap-size
// stimulus, verdict. Depends on ffha_pkg, ffha_checker and the design.
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int PHASE_REQS  = 225;      // random requests per heap setting
    localparam int LIMIT       = 10000000; // cycles before the run is declared hung
    localparam int HOLD_CYCLES = 400;      // long result back-pressure stretch

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [W_OP-1:0]   opcode = OP_NOP;
    logic [W_SIZE-1:0] size_bytes = '0;
    logic [W_ADDR-1:0] address = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [W_ADDR-1:0] result_address;
    logic [W_ST-1:0]   status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [W_HEAP-1:0] cfg_heap = '0;
    int                fail_count, pending;

    int                cycles = 0;
    int                sent = 0;
    bit                calm = 1'b0;      // no idling on either side while set
    bit                hold_go = 1'b0;
    bit                hold_done = 1'b0;
    int                hold_left = 0;
    longint unsigned   heap_now = HEAP_RESET_BYTES;
    logic [W_ADDR-1:0] live [$];         // payload offsets handed out lately

    first_fit_heap_allocator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_size_bytes     (size_bytes),
        .i_address        (address),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_address (result_address),
        .o_status         (status),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_heap_bytes (cfg_heap)
    );

    ffha_checker u_chk (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_in_valid (in_valid), .i_in_ready (in_ready),
        .i_opcode (opcode), .i_size_bytes (size_bytes), .i_address (address),
        .i_out_valid (out_valid), .i_out_ready (out_ready),
        .i_result_address (result_address), .i_status (status),
        .i_cfg_valid (cfg_valid), .i_cfg_ready (cfg_ready), .i_cfg_heap_bytes (cfg_heap),
        .o_fail_count (fail_count), .o_pending (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // remember granted offsets so free and resize mostly hit real blocks
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready && result_address != 0) begin
            live.push_back(result_address);
            if (live.size() > 48) void'(live.pop_front());
        end
    end

    // one request; returns after the edge at which it is taken, or later after a random idle gap
    task automatic put_request(t_opcode op, logic [W_SIZE-1:0] sz, logic [W_ADDR-1:0] ad);
        in_valid   <= 1'b1;
        opcode     <= op;
        size_bytes <= sz;
        address    <= ad;
        do @(posedge i_clk); while (!in_ready);
        sent++;
        if (sent == 300) hold_go = 1'b1;
        calm = (sent >= 700 && sent < 900);
        if (!calm && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // heap size change, only with the block drained
    task automatic set_heap(logic [W_HEAP-1:0] hb);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_heap  <= hb;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        heap_now = (hb < HEAP_MIN_BYTES) ? HEAP_MIN_BYTES :
                   (hb > DEF_HEAP_LIMIT) ? DEF_HEAP_LIMIT : hb;
        live.delete();
    endtask

    function automatic logic [W_SIZE-1:0] pick_size();
        int              r;
        longint unsigned cap;
        r   = $urandom_range(99);
        cap = heap_now / 24;
        if (cap > 4096) cap = 4096;
        if (r < 72) return W_SIZE'($urandom_range(int'(cap), 1));
        if (r < 78) return '0;
        if (r < 88) return W_SIZE'($urandom_range(int'(heap_now), 1));
        if (r < 94) return W_SIZE'($urandom());                 // mostly far too big
        return W_SIZE'(heap_now - DEF_HEADER_BYTES - $urandom_range(9));
    endfunction

    function automatic logic [W_ADDR-1:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (live.size() != 0 && r < 72) return live[$urandom_range(live.size() - 1)];
        if (live.size() != 0 && r < 80)
            return W_ADDR'(live[$urandom_range(live.size() - 1)] +
                           ($urandom_range(1) ? 8 : -8));
        if (r < 88) return '0;
        return W_ADDR'($urandom());
    endfunction

    task automatic random_phase(int n);
        int               r;
        int               k;
        logic [W_ADDR-1:0] ad;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                put_request(OP_ALLOC, pick_size(), W_ADDR'($urandom()));
            end else if (r < 78) begin
                ad = pick_addr();
                // usually forget a freed offset; sometimes keep it for a double free
                if (live.size() != 0 && $urandom_range(9) != 0) begin
                    k = $urandom_range(live.size() - 1);
                    ad = live[k];
                    live.delete(k);
                end
                put_request(OP_FREE, W_SIZE'($urandom()), ad);
            end else if (r < 97) begin
                put_request(OP_RESIZE, pick_size(), pick_addr());
            end else begin
                put_request(OP_NOP, W_SIZE'($urandom()), W_ADDR'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest heap: below-range write clamps up to 4096
        set_heap('0);
        put_request(OP_ALLOC, 0, 0);                    // zero size
        put_request(OP_ALLOC, 1, 0);                    // rounds to 8, offset 48
        put_request(OP_ALLOC, 16, 0);                   // offset 104
        put_request(OP_ALLOC, 24, 0);                   // offset 168
        put_request(OP_ALLOC, 30'h3FFF_FFFF, 0);        // never fits
        put_request(OP_FREE, 0, 0);                     // null free
        put_request(OP_FREE, 0, 29'h1FFF_FFFF);         // not a block
        put_request(OP_FREE, 0, 52);                    // inside a block
        put_request(OP_RESIZE, 8, 104);                 // shrink, too little to split
        put_request(OP_RESIZE, 100, 104);               // grow, moves
        put_request(OP_FREE, 0, 104);                   // already free after move
        put_request(OP_RESIZE, 40, 104);                // resize of free block
        put_request(OP_RESIZE, 20, 0);                  // null resize acts as alloc
        put_request(OP_RESIZE, 0, 168);                 // size zero acts as free
        put_request(OP_RESIZE, 0, 168);                 // second time: merged into the block before, not a block
        put_request(OP_FREE, 0, 48);                    // merge with free next
        put_request(OP_RESIZE, 30'h3FFF_FFFF, 29'h1FFF_FFFF);
        put_request(OP_NOP, 30'h3FFF_FFFF, 29'h1FFF_FFFF);
        put_request(OP_ALLOC, 4000, 0);                 // too large for what is left
        put_request(OP_ALLOC, 4048, 0);
        random_phase(PHASE_REQS - 20);

        set_heap(W_HEAP'(DEF_HEAP_LIMIT));              // largest heap
        put_request(OP_ALLOC, W_SIZE'(DEF_HEAP_LIMIT - DEF_HEADER_BYTES), 0);   // exact fit
        random_phase(PHASE_REQS);
        set_heap(30'h3FFF_FFFF);                        // above range, clamps down
        random_phase(PHASE_REQS);
        set_heap(W_HEAP'(HEAP_RESET_BYTES));
        random_phase(PHASE_REQS);
        set_heap(W_HEAP'($urandom_range(65536, 4096)));
        random_phase(PHASE_REQS);
        set_heap(W_HEAP'($urandom()));
        random_phase(PHASE_REQS);

        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);                  // catch any stray result
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
